@@ sv/acs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_pkg
// Operation codes and control register indexes of the attenuator code picker.
// ----------------------------------------------------------------------------
package acs_pkg;

   localparam int OP_W   = 2;
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 10;
   localparam int CODE_W = 6;
   localparam int GAIN_W = 16;
   localparam int CHAN_W = 10;

   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_SELECT = 2'd1;
   localparam logic [OP_W-1:0] OP_APPLY  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   localparam logic [CSR_IW-1:0] CSR_BAND_SPLIT = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_DEF_LOW0   = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_DEF_LOW1   = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_DEF_HIGH0  = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_DEF_HIGH1  = 3'd4;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_WRAP = 8'b0000_0010,
      S_ROW  = 8'b0000_0100,
      S_BASE = 8'b0000_1000,
      S_DEF  = 8'b0001_0000,
      S_SCAN = 8'b0010_0000,
      S_LAST = 8'b0100_0000,
      S_CALC = 8'b1000_0000
   } state_type;

endpackage

@@ sv/acs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_ram
// Single port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module acs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                        wdata,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/attenuator_code_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attenuator_code_select
// Calibrated attenuator code picker over a gain table held in one RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A write request
// stores one table entry; a select request walks every code of the row and
// picks the one whose gain relative to the band default is nearest to the
// target (lowest code on a tie); an apply request uses the given code. Select
// and apply give one result, strobed on rsp_strobe for a single cycle, which
// the receiver must take then. All table reads go through the one RAM port,
// one entry a cycle. A request passes through the row, base and default
// states; a write stores its entry in the default state, while a select or
// apply goes through the scan and last states and forms its result in the calc
// state. When NUM_CHANNELS is below 1024 the channel is first reduced in the
// wrap state by a reciprocal multiplication and a subtraction. Table entries
// are undefined until written and there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module attenuator_code_select
   import acs_pkg::*;
#(
   parameter int NUM_CHANNELS = 1024,
   parameter int NUM_CODES    = 51,
   parameter int NUM_UNITS    = 2,
   parameter int NUM_DEVICES  = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_op,
   input  logic [CHAN_W-1:0]        req_channel,
   input  logic                     req_unit_sel,
   input  logic                     req_device_sel,
   input  logic [CODE_W-1:0]        req_code_in,
   input  logic signed [GAIN_W-1:0] req_entry_value,
   input  logic signed [GAIN_W-1:0] req_target_gain,
   output logic                     rsp_strobe,
   output logic [CODE_W-1:0]        rsp_code_out,
   output logic signed [GAIN_W-1:0] rsp_remaining_gain,
   input  logic                     csr_we,
   input  logic [CSR_IW-1:0]        csr_index,
   input  logic [CSR_DW-1:0]        csr_wdata
);

   localparam int ROWS  = NUM_CHANNELS * NUM_UNITS * NUM_DEVICES;
   localparam int DEPTH = ROWS * NUM_CODES;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int RW    = ROWS > 1 ? $clog2(ROWS) : 1;
   localparam int CW    = $clog2(NUM_CODES);
   localparam int CHW   = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
   localparam int XW    = RW + 4;
   localparam int MW    = AW + CODE_W + 1;
   localparam int DW    = 18;
   localparam bit NEED_WRAP = NUM_CHANNELS < (1 << CHAN_W);
   localparam int STEP_W  = 1;
   localparam int WMUL_W  = 2 * CHAN_W;
   localparam int WRAP_SH = 2 * CHAN_W;
   localparam int RECIP_W = WRAP_SH + 1;
   localparam int PROD_W  = CHAN_W + RECIP_W;

   localparam logic [CW-1:0]     CODE_MAX = CW'(NUM_CODES - 1);
   localparam logic [CODE_W-1:0] CODE_MAX_IN = CODE_W'(NUM_CODES - 1);
   localparam logic [RECIP_W-1:0] WRAP_RECIP =
      RECIP_W'(((1 << WRAP_SH) + NUM_CHANNELS - 1) / NUM_CHANNELS);

   function automatic logic signed [DW-1:0] sx(input logic [GAIN_W-1:0] v);
      sx = signed'({{(DW-GAIN_W){v[GAIN_W-1]}}, v});
   endfunction

   function automatic logic [CW-1:0] clamp_code(input logic [CODE_W-1:0] c);
      clamp_code = (c > CODE_MAX_IN) ? CODE_MAX : CW'(c);
   endfunction

   // control registers
   logic [CHAN_W-1:0] band_split_ff;
   logic [CODE_W-1:0] def_low0_ff, def_low1_ff, def_high0_ff, def_high1_ff;

   state_type state_ff, state_in;

   logic [OP_W-1:0]          op_ff, op_in;
   logic [CHAN_W-1:0]        channel_ff, channel_in;
   logic                     unit_ff, unit_in;
   logic                     dev_ff, dev_in;
   logic [CW-1:0]            code_ff, code_in;
   logic [GAIN_W-1:0]        entry_ff, entry_in;
   logic [GAIN_W-1:0]        target_ff, target_in;
   logic [CHAN_W-1:0]        wrap_ff, wrap_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [RW-1:0]            row_ff, row_in;
   logic [AW-1:0]            base_ff, base_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     pend_def_ff, pend_def_in;
   logic [CW-1:0]            pend_code_ff, pend_code_in;
   logic [GAIN_W-1:0]        dgain_ff, dgain_in;
   logic [DW-1:0]            best_d_ff, best_d_in;
   logic [CW-1:0]            best_code_ff, best_code_in;
   logic [GAIN_W-1:0]        best_gain_ff, best_gain_in;
   logic                     strobe_ff, strobe_in;
   logic [CODE_W-1:0]        rsp_code_ff, rsp_code_in;
   logic [GAIN_W-1:0]        rsp_gain_ff, rsp_gain_in;

   logic                     mem_we;
   logic [AW-1:0]            mem_addr;
   logic [GAIN_W-1:0]        mem_wdata;
   logic [GAIN_W-1:0]        mem_rdata;

   logic [CHW-1:0]           ch_idx;
   logic                     unit_idx, dev_idx;
   logic                     high_band;
   logic [CW-1:0]            dcode;
   logic [CW-1:0]            scan_code;
   logic                     scan_last;
   logic [PROD_W-1:0]        wrap_prod;
   logic signed [DW-1:0]     diff;
   logic [DW-1:0]            delta_mag;
   logic                     take;
   logic signed [DW-1:0]     rem_full;

   acs_ram #(
      .WIDTH (GAIN_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // index reduction
   assign ch_idx    = NEED_WRAP ? CHW'(wrap_ff) : CHW'(channel_ff);
   assign unit_idx  = (NUM_UNITS > 1) ? unit_ff : 1'b0;
   assign dev_idx   = (NUM_DEVICES > 1) ? dev_ff : 1'b0;
   assign high_band = channel_ff >= band_split_ff;
   assign wrap_prod = PROD_W'(channel_ff) * PROD_W'(WRAP_RECIP);

   always_comb begin
      priority if (high_band) begin
         dcode = clamp_code(dev_idx ? def_high1_ff : def_high0_ff);
      end else begin
         dcode = clamp_code(dev_idx ? def_low1_ff : def_low0_ff);
      end
   end

   assign scan_code = (op_ff == OP_SELECT) ? cnt_ff : code_ff;
   assign scan_last = (op_ff == OP_SELECT) ? (cnt_ff == CODE_MAX) : 1'b1;

   // distance of the arriving entry from the target
   assign diff = sx(mem_rdata) - sx(dgain_ff) - sx(target_ff);
   assign delta_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
   assign take = (op_ff != OP_SELECT) || (pend_code_ff == '0) || (delta_mag < best_d_ff);

   assign rem_full = sx(target_ff) - (sx(best_gain_ff) - sx(dgain_ff));

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      channel_in   = channel_ff;
      unit_in      = unit_ff;
      dev_in       = dev_ff;
      code_in      = code_ff;
      entry_in     = entry_ff;
      target_in    = target_ff;
      wrap_in      = wrap_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      pend_def_in  = pend_def_ff;
      pend_code_in = pend_code_ff;
      dgain_in     = dgain_ff;
      best_d_in    = best_d_ff;
      best_code_in = best_code_ff;
      best_gain_in = best_gain_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_gain_in  = rsp_gain_ff;
      strobe_in    = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = AW'(base_ff + AW'(scan_code));
      mem_wdata    = entry_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = req_op;
               channel_in = req_channel;
               unit_in    = req_unit_sel;
               dev_in     = req_device_sel;
               code_in    = clamp_code(req_code_in);
               entry_in   = req_entry_value;
               target_in  = req_target_gain;
               wrap_in    = req_channel;
               step_in    = '0;
               if (req_op != OP_NONE) begin
                  state_in = NEED_WRAP ? S_WRAP : S_ROW;
               end
            end
         end
         S_WRAP: begin
            // quotient by reciprocal multiplication, then remainder
            if (step_ff == '0) begin
               wrap_in = wrap_prod[WRAP_SH+CHAN_W-1:WRAP_SH];
               step_in = 1'b1;
            end else begin
               wrap_in  = channel_ff - CHAN_W'(WMUL_W'(wrap_ff) * WMUL_W'(NUM_CHANNELS));
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            row_in   = RW'((XW'(ch_idx) * XW'(NUM_UNITS) + XW'(unit_idx)) * XW'(NUM_DEVICES)
                           + XW'(dev_idx));
            state_in = S_BASE;
         end
         S_BASE: begin
            base_in  = AW'(MW'(row_ff) * MW'(NUM_CODES));
            state_in = S_DEF;
         end
         S_DEF: begin
            cnt_in = '0;
            if (op_ff == OP_WRITE) begin
               mem_we   = 1'b1;
               mem_addr = AW'(base_ff + AW'(code_ff));
               state_in = S_IDLE;
            end else begin
               mem_addr    = AW'(base_ff + AW'(dcode));
               pend_def_in = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            pend_def_in  = 1'b0;
            pend_code_in = scan_code;
            cnt_in       = cnt_ff + 1'b1;
            if (pend_def_ff) begin
               dgain_in = mem_rdata;
            end else if (take) begin
               best_d_in    = delta_mag;
               best_code_in = pend_code_ff;
               best_gain_in = mem_rdata;
            end
            if (scan_last) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            if (take) begin
               best_d_in    = delta_mag;
               best_code_in = pend_code_ff;
               best_gain_in = mem_rdata;
            end
            state_in = S_CALC;
         end
         S_CALC: begin
            rsp_code_in = CODE_W'(best_code_ff);
            priority if (rem_full > DW'(signed'(32767))) begin
               rsp_gain_in = 16'h7fff;
            end else if (rem_full < -DW'(signed'(32768))) begin
               rsp_gain_in = 16'h8000;
            end else begin
               rsp_gain_in = rem_full[GAIN_W-1:0];
            end
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         strobe_ff     <= 1'b0;
         band_split_ff <= '0;
         def_low0_ff   <= '0;
         def_low1_ff   <= '0;
         def_high0_ff  <= '0;
         def_high1_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_BAND_SPLIT: band_split_ff <= csr_wdata;
               CSR_DEF_LOW0:   def_low0_ff   <= csr_wdata[CODE_W-1:0];
               CSR_DEF_LOW1:   def_low1_ff   <= csr_wdata[CODE_W-1:0];
               CSR_DEF_HIGH0:  def_high0_ff  <= csr_wdata[CODE_W-1:0];
               CSR_DEF_HIGH1:  def_high1_ff  <= csr_wdata[CODE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      channel_ff   <= channel_in;
      unit_ff      <= unit_in;
      dev_ff       <= dev_in;
      code_ff      <= code_in;
      entry_ff     <= entry_in;
      target_ff    <= target_in;
      wrap_ff      <= wrap_in;
      step_ff      <= step_in;
      row_ff       <= row_in;
      base_ff      <= base_in;
      cnt_ff       <= cnt_in;
      pend_def_ff  <= pend_def_in;
      pend_code_ff <= pend_code_in;
      dgain_ff     <= dgain_in;
      best_d_ff    <= best_d_in;
      best_code_ff <= best_code_in;
      best_gain_ff <= best_gain_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_gain_ff  <= rsp_gain_in;
   end

   assign busy               = state_ff != S_IDLE;
   assign rsp_strobe         = strobe_ff;
   assign rsp_code_out       = rsp_code_ff;
   assign rsp_remaining_gain = signed'(rsp_gain_ff);

endmodule

@@ verif/attenuator_code_select_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attenuator_code_select_tb
// Self-checking bench for the calibrated attenuator code picker.
// ----------------------------------------------------------------------------
// Rows of the gain table are loaded in full before any select or apply
// touches them, so no unwritten entry is ever read. A short directed table
// covers ties, saturation, band choice, code clamping and the unused op code;
// then random phases change the control registers, load fresh rows and mix
// selects, applies, writes and ignored requests with random idle gaps. Every
// result is checked field by field against the given value for a typed
// directed row, else against a bench shadow of the table and the registers.
// ----------------------------------------------------------------------------
module attenuator_code_select_tb;
   import acs_pkg::*;

   localparam int N_CHAN          = 1024;
   localparam int N_CODE          = 51;
   localparam int N_UNIT          = 2;
   localparam int N_DEV           = 2;
   localparam int LAST_CODE       = N_CODE - 1;
   localparam int SETTLE_CYCLES   = 70;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int N_PHASES        = 8;
   localparam int MIXED_PER_PHASE = 80;
   localparam int N_DIR           = 23;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [CHAN_W-1:0]        channel;
      logic                     unit_sel;
      logic                     device_sel;
      logic [CODE_W-1:0]        code_in;
      logic signed [GAIN_W-1:0] entry_value;
      logic signed [GAIN_W-1:0] target_gain;
   } acs_req_type;

   typedef struct packed {
      logic [CODE_W-1:0]        code;
      logic signed [GAIN_W-1:0] gain;
   } acs_rsp_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic              unit_sel;
      logic              device_sel;
   } row_type;

   typedef struct {
      acs_req_type req;
      bit          typed;
      acs_rsp_type want;
   } dir_row_type;

   typedef enum int {FILL_ZERO, FILL_RAMP, FILL_RANDOM, FILL_NARROW} fill_type;

   localparam int REQ_W = $bits(acs_req_type);
   localparam int ROW_W = $bits(row_type);

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [OP_W-1:0]          req_op = '0;
   logic [CHAN_W-1:0]        req_channel = '0;
   logic                     req_unit_sel = 1'b0;
   logic                     req_device_sel = 1'b0;
   logic [CODE_W-1:0]        req_code_in = '0;
   logic signed [GAIN_W-1:0] req_entry_value = '0;
   logic signed [GAIN_W-1:0] req_target_gain = '0;
   logic                     rsp_strobe;
   logic [CODE_W-1:0]        rsp_code_out;
   logic signed [GAIN_W-1:0] rsp_remaining_gain;
   logic                     csr_we = 1'b0;
   logic [CSR_IW-1:0]        csr_index = '0;
   logic [CSR_DW-1:0]        csr_wdata = '0;

   // shadow of the gain table and the control registers
   logic signed [GAIN_W-1:0] gain_mem [int];
   logic [CHAN_W-1:0]        band_split = '0;
   logic [CODE_W-1:0]        def_code [4] = '{default: '0};

   acs_rsp_type pending_codes [$];
   row_type     loaded_rows [$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          burst_mode = 1'b0;

   dir_row_type dir_tab [N_DIR] = '{
      '{'{OP_SELECT, 10'd0,    1'b0, 1'b0, 6'd0,  16'sh0000, 16'sh0000}, 1'b1, '{6'd0,  16'sh0000}},
      '{'{OP_WRITE,  10'd0,    1'b0, 1'b0, 6'd0,  16'sh7FFF, 16'sh0000}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_APPLY,  10'd0,    1'b0, 1'b0, 6'd0,  16'sh0000, 16'sh8000}, 1'b1, '{6'd0,  16'sh8000}},
      '{'{OP_WRITE,  10'd0,    1'b0, 1'b0, 6'd63, 16'sh8000, 16'sh0000}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_APPLY,  10'd0,    1'b0, 1'b0, 6'd63, 16'sh0000, 16'sh7FFF}, 1'b1, '{6'd50, 16'sh7FFF}},
      '{'{OP_SELECT, 10'd0,    1'b0, 1'b0, 6'd0,  16'sh0000, 16'sh0000}, 1'b1, '{6'd1,  16'sh0000}},
      '{'{OP_SELECT, 10'd0,    1'b0, 1'b0, 6'd0,  16'sh0000, 16'sh8000}, 1'b1, '{6'd50, 16'sh0000}},
      '{'{OP_SELECT, 10'd0,    1'b0, 1'b0, 6'd0,  16'sh0000, 16'sh7FFF}, 1'b1, '{6'd0,  16'sh0000}},
      '{'{OP_WRITE,  10'd1023, 1'b1, 1'b1, 6'd50, 16'sh0100, 16'sh0000}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_APPLY,  10'd1023, 1'b1, 1'b1, 6'd0,  16'sh0000, 16'sh0000}, 1'b1, '{6'd0,  16'sh0100}},
      '{'{OP_SELECT, 10'd1023, 1'b1, 1'b1, 6'd0,  16'sh0000, 16'shFF00}, 1'b1, '{6'd0,  16'sh0000}},
      '{'{OP_SELECT, 10'd1023, 1'b1, 1'b1, 6'd0,  16'sh0000, 16'sh0000}, 1'b1, '{6'd50, 16'sh0000}},
      '{'{OP_APPLY,  10'd511,  1'b0, 1'b0, 6'd20, 16'sh0000, 16'sh0000}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_APPLY,  10'd512,  1'b0, 1'b0, 6'd20, 16'sh0000, 16'sh0000}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_SELECT, 10'd511,  1'b0, 1'b0, 6'd0,  16'sh0000, 16'sh0064}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_SELECT, 10'd512,  1'b0, 1'b0, 6'd0,  16'sh0000, 16'shFF9C}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_NONE,   10'd1023, 1'b1, 1'b1, 6'd63, 16'shFFFF, 16'shFFFF}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_NONE,   10'd0,    1'b0, 1'b0, 6'd0,  16'sh0000, 16'sh0000}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_WRITE,  10'd511,  1'b0, 1'b0, 6'd7,  16'sh8000, 16'sh0000}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_SELECT, 10'd511,  1'b0, 1'b0, 6'd0,  16'sh0000, 16'sh0000}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_APPLY,  10'd100,  1'b0, 1'b1, 6'd50, 16'sh0000, 16'sh3039}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_SELECT, 10'd100,  1'b0, 1'b1, 6'd0,  16'sh0000, 16'shCFC7}, 1'b0, '{6'd0,  16'sh0000}},
      '{'{OP_APPLY,  10'd512,  1'b0, 1'b0, 6'd63, 16'sh0000, 16'shFFFF}, 1'b0, '{6'd0,  16'sh0000}}
   };

   attenuator_code_select dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_channel        (req_channel),
      .req_unit_sel       (req_unit_sel),
      .req_device_sel     (req_device_sel),
      .req_code_in        (req_code_in),
      .req_entry_value    (req_entry_value),
      .req_target_gain    (req_target_gain),
      .rsp_strobe         (rsp_strobe),
      .rsp_code_out       (rsp_code_out),
      .rsp_remaining_gain (rsp_remaining_gain),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CODE_W-1:0] sat_code(input logic [CODE_W-1:0] c);
      return (c > LAST_CODE) ? CODE_W'(LAST_CODE) : c;
   endfunction

   function automatic int entry_index(input logic [CHAN_W-1:0] ch, input logic unit,
                                      input logic dev, input logic [CODE_W-1:0] code);
      return ((int'(ch) % N_CHAN * N_UNIT + int'(unit) % N_UNIT) * N_DEV
              + int'(dev) % N_DEV) * N_CODE + int'(sat_code(code));
   endfunction

   function automatic int table_gain(input logic [CHAN_W-1:0] ch, input logic unit,
                                     input logic dev, input logic [CODE_W-1:0] code);
      int idx;
      idx = entry_index(ch, unit, dev, code);
      return gain_mem.exists(idx) ? int'(gain_mem[idx]) : 0;
   endfunction

   // gain of a code relative to the default code of the channel's band
   function automatic int rel_gain(input logic [CHAN_W-1:0] ch, input logic unit,
                                   input logic dev, input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] dcode;
      dcode = sat_code(def_code[{ch >= band_split, dev}]);
      return table_gain(ch, unit, dev, code) - table_gain(ch, unit, dev, dcode);
   endfunction

   function automatic bit predict_code_pick(input acs_req_type r, output acs_rsp_type rsp);
      int                best;
      int                delta;
      int                rem;
      int                k;
      logic [CODE_W-1:0] pick;
      rsp = '0;
      pick = '0;
      case (r.op)
         OP_WRITE: begin
            gain_mem[entry_index(r.channel, r.unit_sel, r.device_sel, r.code_in)] =
               r.entry_value;
            return 1'b0;
         end
         OP_SELECT: begin
            best = rel_gain(r.channel, r.unit_sel, r.device_sel, '0) - int'(r.target_gain);
            if (best < 0) best = -best;
            for (k = 1; k < N_CODE; k++) begin
               delta = rel_gain(r.channel, r.unit_sel, r.device_sel, CODE_W'(k))
                       - int'(r.target_gain);
               if (delta < 0) delta = -delta;
               // strictly nearer only, so a tie keeps the lower code
               if (delta < best) begin
                  best = delta;
                  pick = CODE_W'(k);
               end
            end
         end
         OP_APPLY: begin
            pick = sat_code(r.code_in);
         end
         default: begin
            return 1'b0;
         end
      endcase
      rem = int'(r.target_gain) - rel_gain(r.channel, r.unit_sel, r.device_sel, pick);
      if (rem > 32767) rem = 32767;
      if (rem < -32768) rem = -32768;
      rsp.code = pick;
      rsp.gain = GAIN_W'(rem);
      return 1'b1;
   endfunction

   function automatic logic [CSR_DW-1:0] pick_default();
      if ($urandom_range(0, 4) == 0) return CSR_DW'($urandom_range(N_CODE, 63));
      return CSR_DW'($urandom_range(0, LAST_CODE));
   endfunction

   task automatic idle_gap();
      int gap;
      int p;
      p = $urandom_range(0, 99);
      if (burst_mode || p < 45) gap = 0;
      else if (p < 85) gap = $urandom_range(1, 3);
      else if (p < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send(input acs_req_type r, input bit typed, input acs_rsp_type want);
      acs_rsp_type got;
      req_op          <= r.op;
      req_channel     <= r.channel;
      req_unit_sel    <= r.unit_sel;
      req_device_sel  <= r.device_sel;
      req_code_in     <= r.code_in;
      req_entry_value <= r.entry_value;
      req_target_gain <= r.target_gain;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (predict_code_pick(r, got)) pending_codes.push_back(typed ? want : got);
      idle_gap();
   endtask

   task automatic set_registers(input logic [CSR_DW-1:0] split, input logic [CSR_DW-1:0] lo0,
                                input logic [CSR_DW-1:0] lo1, input logic [CSR_DW-1:0] hi0,
                                input logic [CSR_DW-1:0] hi1);
      logic [CSR_IW-1:0] idx [5];
      logic [CSR_DW-1:0] val [5];
      int                i;
      idx = '{CSR_BAND_SPLIT, CSR_DEF_LOW0, CSR_DEF_LOW1, CSR_DEF_HIGH0, CSR_DEF_HIGH1};
      val = '{split, lo0, lo1, hi0, hi1};
      for (i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         case (idx[i])
            CSR_BAND_SPLIT: band_split = val[i][CHAN_W-1:0];
            CSR_DEF_LOW0:   def_code[0] = val[i][CODE_W-1:0];
            CSR_DEF_LOW1:   def_code[1] = val[i][CODE_W-1:0];
            CSR_DEF_HIGH0:  def_code[2] = val[i][CODE_W-1:0];
            CSR_DEF_HIGH1:  def_code[3] = val[i][CODE_W-1:0];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // writes every code of a row so selects on it never read a blank entry
   task automatic load_row(input row_type rw, input fill_type kind);
      acs_req_type r;
      int          k;
      int          base;
      int          step;
      int          v;
      base = int'($urandom_range(0, 4000)) - 2000;
      step = int'($urandom_range(0, 1200)) - 600;
      for (k = 0; k < N_CODE; k++) begin
         r = acs_req_type'(REQ_W'({$urandom, $urandom}));
         r.op = OP_WRITE;
         r.channel = rw.channel;
         r.unit_sel = rw.unit_sel;
         r.device_sel = rw.device_sel;
         r.code_in = CODE_W'(k);
         case (kind)
            FILL_RAMP:   v = base + k * step;
            FILL_RANDOM: v = int'($urandom);
            FILL_NARROW: v = int'($urandom_range(0, 8)) - 4;
            default:     v = 0;
         endcase
         r.entry_value = GAIN_W'(v);
         send(r, 1'b0, '0);
      end
      loaded_rows.push_back(rw);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_codes.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_results
      acs_rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_codes.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with no request pending: code %0d gain %0d",
                     $time, rsp_code_out, rsp_remaining_gain);
         end else begin
            want = pending_codes.pop_front();
            if (rsp_code_out !== want.code) begin
               mismatch_count++;
               $display("%0t: code_out expected %0d actual %0d",
                        $time, want.code, rsp_code_out);
            end
            if (rsp_remaining_gain !== want.gain) begin
               mismatch_count++;
               $display("%0t: remaining_gain expected %0d actual %0d",
                        $time, want.gain, rsp_remaining_gain);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("attenuator_code_select regression: fail");
      $finish;
   end

   initial begin
      acs_req_type r;
      row_type     rw;
      int          ph;
      int          n;
      int          p;
      int          k;
      int          t;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part
      set_registers(10'd512, 10'd7, 10'd0, 10'd0, 10'd63);
      load_row('{10'd0, 1'b0, 1'b0}, FILL_ZERO);
      load_row('{10'd1023, 1'b1, 1'b1}, FILL_ZERO);
      load_row('{10'd511, 1'b0, 1'b0}, FILL_RAMP);
      load_row('{10'd512, 1'b0, 1'b0}, FILL_RAMP);
      load_row('{10'd100, 1'b0, 1'b1}, FILL_RANDOM);
      for (k = 0; k < N_DIR; k++) send(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].want);

      // random phases
      for (ph = 0; ph < N_PHASES; ph++) begin
         drain();
         burst_mode = (ph % 3 == 2);
         if (ph == 0) set_registers('0, '0, '0, '0, '0);
         else if (ph == 1) set_registers(10'h3FF, 10'h3F, 10'h3F, 10'h3F, 10'h3F);
         else set_registers(CSR_DW'($urandom_range(0, N_CHAN - 1)), pick_default(),
                            pick_default(), pick_default(), pick_default());
         repeat (2) load_row(row_type'(ROW_W'($urandom)), fill_type'($urandom_range(0, 3)));
         n = 0;
         while (n < MIXED_PER_PHASE) begin
            rw = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
            r = acs_req_type'(REQ_W'({$urandom, $urandom}));
            r.channel = rw.channel;
            r.unit_sel = rw.unit_sel;
            r.device_sel = rw.device_sel;
            p = $urandom_range(0, 99);
            if (p < 40) begin
               r.op = OP_SELECT;
               // aim near one code's relative gain to provoke close calls and ties
               if (p < 22) begin
                  t = rel_gain(rw.channel, rw.unit_sel, rw.device_sel,
                               CODE_W'($urandom_range(0, LAST_CODE)))
                      + int'($urandom_range(0, 6)) - 3;
                  r.target_gain = GAIN_W'(t);
               end
            end else if (p < 70) begin
               r.op = OP_APPLY;
               if ($urandom_range(0, 4) == 0) r.code_in = CODE_W'($urandom_range(N_CODE, 63));
               else r.code_in = CODE_W'($urandom_range(0, LAST_CODE));
               case ($urandom_range(0, 9))
                  0: r.target_gain = 16'sh7FFF;
                  1: r.target_gain = 16'sh8000;
                  default: ;
               endcase
            end else if (p < 85) begin
               r.op = OP_WRITE;
            end else if (p < 92) begin
               r.op = OP_WRITE;
               {r.channel, r.unit_sel, r.device_sel} = ROW_W'($urandom);
            end else begin
               r.op = OP_NONE;
            end
            send(r, 1'b0, '0);
            if (r.op != OP_NONE) n++;
         end
      end

      drain();
      if (mismatch_count == 0) begin
         $display("attenuator_code_select regression: pass");
      end else begin
         $display("attenuator_code_select regression: fail");
      end
      $finish;
   end

endmodule
